### hdl/bubble_command_parser_macros.svh
// Assertion macros for the bubble command parser checker.
// Expect a clock named clk and an active-high reset named rst in scope.
`ifndef BUBBLE_COMMAND_PARSER_MACROS_SVH
`define BUBBLE_COMMAND_PARSER_MACROS_SVH

// same-cycle implication
`define BCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bubble_command_parser: same-cycle check failed");

// next-cycle implication
`define BCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bubble_command_parser: next-cycle check failed");

`endif

### hdl/bcp_pkg.sv
// Shared types and character constants for the bubble command parser.
// No dependencies.
package bcp_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_LOWER_Y = 8'h79;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_LOWER_R = 8'h72;

  localparam int unsigned ACC_BITS = 15;
  localparam int unsigned TAG_BITS = 5;
  localparam logic [ACC_BITS-1:0] ACC_MAX   = 15'd32767;
  localparam logic [TAG_BITS-1:0] TAG_RESET = 5'd23;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIGIT,
    OP_MINUS,
    OP_PLUS,
    OP_SET_X,
    OP_SET_Y,
    OP_SET_Z,
    OP_RECORD,
    OP_END,
    OP_TAG
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [3:0]          digit;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

endpackage

### hdl/bcp_decode.sv
// Character classifier: maps one input word to a parser command.
// Depends on bcp_pkg.
module bcp_decode (
  input  logic [7:0]   char_in,
  output bcp_pkg::cmd_t cmd
);
  import bcp_pkg::*;

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.digit = char_in[3:0];
    cmd.tag   = TAG_BITS'(char_in - CHAR_UPPER_A);
    if (char_in == CHAR_UPPER_X) begin
      cmd.op = OP_END;
    end else if (char_in >= CHAR_UPPER_A && char_in <= CHAR_UPPER_Z) begin
      cmd.op = OP_TAG;
    end else if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
      cmd.op = OP_DIGIT;
    end else begin
      case (char_in)
        CHAR_MINUS:   cmd.op = OP_MINUS;
        CHAR_PLUS:    cmd.op = OP_PLUS;
        CHAR_LOWER_X: cmd.op = OP_SET_X;
        CHAR_LOWER_Y: cmd.op = OP_SET_Y;
        CHAR_LOWER_Z: cmd.op = OP_SET_Z;
        CHAR_LOWER_R: cmd.op = OP_RECORD;
        default:      cmd.op = OP_NONE;
      endcase
    end
  end

endmodule

### hdl/bcp_state.sv
// Parser state: accumulator, sign, coordinates and tag, plus result forming.
// Depends on bcp_pkg.
module bcp_state #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  bcp_pkg::cmd_t               cmd,
  output logic                        emit,
  output logic                        res_kind,
  output logic signed [COORD_BITS-1:0] res_x,
  output logic signed [COORD_BITS-1:0] res_y,
  output logic signed [COORD_BITS-1:0] res_depth,
  output logic [bcp_pkg::ACC_BITS-1:0] res_radius,
  output logic [bcp_pkg::TAG_BITS-1:0] res_tag
);
  import bcp_pkg::*;

  localparam logic [32:0] LIMIT = (33'd1 << (COORD_BITS - 1)) - 33'd1;

  logic [ACC_BITS-1:0]          accum, accum_next;
  logic                         negative, negative_next;
  logic signed [COORD_BITS-1:0] cur_x, cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y, cur_y_next;
  logic signed [COORD_BITS-1:0] cur_depth, cur_depth_next;
  logic [TAG_BITS-1:0]          cur_tag, cur_tag_next;

  logic [ACC_BITS+3:0] grown;
  logic [32:0]         mag;
  logic [32:0]         pos_val, neg_val;
  logic [COORD_BITS-1:0] coord_signed, coord_negated;

  always_comb begin
    grown = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + {15'd0, cmd.digit};
    mag   = ({18'd0, accum} > LIMIT) ? LIMIT : {18'd0, accum};
    pos_val = mag;
    neg_val = 33'd0 - mag;
    coord_signed  = negative ? neg_val[COORD_BITS-1:0] : pos_val[COORD_BITS-1:0];
    coord_negated = negative ? pos_val[COORD_BITS-1:0] : neg_val[COORD_BITS-1:0];
  end

  always_comb begin
    accum_next     = accum;
    negative_next  = negative;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    cur_depth_next = cur_depth;
    cur_tag_next   = cur_tag;
    emit           = 1'b0;
    res_kind       = 1'b0;
    res_x          = cur_x;
    res_y          = cur_y;
    res_depth      = cur_depth;
    res_radius     = accum;
    res_tag        = cur_tag;
    case (cmd.op)
      OP_DIGIT: begin
        accum_next = (grown > {4'd0, ACC_MAX}) ? ACC_MAX : grown[ACC_BITS-1:0];
      end
      OP_MINUS: begin
        accum_next    = '0;
        negative_next = 1'b1;
      end
      OP_PLUS: begin
        accum_next    = '0;
        negative_next = 1'b0;
      end
      OP_SET_X: begin
        cur_x_next    = coord_signed;
        accum_next    = '0;
        negative_next = 1'b0;
      end
      OP_SET_Y: begin
        cur_y_next    = coord_signed;
        accum_next    = '0;
        negative_next = 1'b0;
      end
      OP_SET_Z: begin
        cur_depth_next = coord_negated;
        accum_next     = '0;
        negative_next  = 1'b0;
      end
      OP_RECORD: begin
        emit          = 1'b1;
        accum_next    = '0;
        negative_next = 1'b0;
      end
      OP_END: begin
        emit           = 1'b1;
        res_kind       = 1'b1;
        res_x          = '0;
        res_y          = '0;
        res_depth      = '0;
        res_radius     = '0;
        res_tag        = '0;
        accum_next     = '0;
        negative_next  = 1'b0;
        cur_x_next     = '0;
        cur_y_next     = '0;
        cur_depth_next = '0;
        cur_tag_next   = TAG_RESET;
      end
      OP_TAG: begin
        cur_tag_next = cmd.tag;
      end
      default: begin
        accum_next = accum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum     <= '0;
      negative  <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_depth <= '0;
      cur_tag   <= TAG_RESET;
    end else if (fire) begin
      accum     <= accum_next;
      negative  <= negative_next;
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      cur_depth <= cur_depth_next;
      cur_tag   <= cur_tag_next;
    end
  end

endmodule

### hdl/bubble_command_parser.sv
// Bubble command parser: takes one ASCII character word per cycle, unless
// in_stall is high, and emits bubble records and end-of-list markers.
// Depends on bcp_pkg, bcp_decode and bcp_state.
//
// Input channel: in_valid, in_stall, char_in. A word is taken at a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall and the result fields kind, pos_x,
// pos_y, pos_depth, radius and tag_index. Only 'r' and 'X' produce a result.
// A character taken at an accept edge lands in the input register; it is
// parsed and its result loaded into the output register at the first later
// edge on which the output register is empty or out_stall is low.
// Throughput: one character per cycle while no pending result is stalled,
// set by the single parse step between the input and output registers.
// Reset (rst, synchronous) empties both registers and returns the parser
// state to zero coordinates, positive sign and tag letter X.
// While out_stall holds a pending result, the parse step halts and in_stall
// rises once the input register is also occupied; no word is dropped.
module bubble_command_parser #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   char_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_depth,
  output logic [bcp_pkg::ACC_BITS-1:0] radius,
  output logic [bcp_pkg::TAG_BITS-1:0] tag_index
);
  import bcp_pkg::*;

  logic       char_valid;
  logic [7:0] char_r;
  logic       advance;
  logic       fire;
  cmd_t       cmd;

  logic                         emit;
  logic                         res_kind;
  logic signed [COORD_BITS-1:0] res_x, res_y, res_depth;
  logic [ACC_BITS-1:0]          res_radius;
  logic [TAG_BITS-1:0]          res_tag;

  assign advance  = !out_valid || !out_stall;
  assign fire     = char_valid && advance;
  assign in_stall = char_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!in_stall) begin
      char_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_r <= char_in;
    end
  end

  bcp_decode u_decode (
    .char_in (char_r),
    .cmd     (cmd)
  );

  bcp_state #(.COORD_BITS(COORD_BITS)) u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (cmd),
    .emit       (emit),
    .res_kind   (res_kind),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_depth  (res_depth),
    .res_radius (res_radius),
    .res_tag    (res_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind      <= res_kind;
      pos_x     <= res_x;
      pos_y     <= res_y;
      pos_depth <= res_depth;
      radius    <= res_radius;
      tag_index <= res_tag;
    end
  end

endmodule

### hdl/bcp_checker.sv
// Port-level checks for the bubble command parser, bound to the top level.
// Depends on bcp_pkg and bubble_command_parser_macros.svh.
`include "bubble_command_parser_macros.svh"

module bcp_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         kind,
  input logic signed [COORD_BITS-1:0] pos_x,
  input logic signed [COORD_BITS-1:0] pos_y,
  input logic signed [COORD_BITS-1:0] pos_depth,
  input logic [bcp_pkg::ACC_BITS-1:0] radius,
  input logic [bcp_pkg::TAG_BITS-1:0] tag_index
);
  import bcp_pkg::*;

  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [TAG_BITS-1:0]   TAG_LAST  = 5'd25;

  `BCP_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `BCP_ASSERT_NEXT(a_hold_word, out_valid && out_stall,
                   $stable(kind) && $stable(radius) && $stable(tag_index))
  `BCP_ASSERT_NOW(a_end_clean, out_valid && kind,
                  pos_x == '0 && pos_y == '0 && pos_depth == '0 &&
                  radius == '0 && tag_index == '0)
  `BCP_ASSERT_NOW(a_record_range, out_valid && !kind,
                  pos_x != COORD_MIN && pos_y != COORD_MIN &&
                  pos_depth != COORD_MIN && tag_index <= TAG_LAST)

endmodule

bind bubble_command_parser bcp_checker #(.COORD_BITS(COORD_BITS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .pos_x     (pos_x),
  .pos_y     (pos_y),
  .pos_depth (pos_depth),
  .radius    (radius),
  .tag_index (tag_index)
);
